FILE: src/dat_pkg.sv
// dat_pkg: shared types and constants for the daily alarm table
// used by dat_seq and multi_slot_daily_alarm_table_core
package dat_pkg;

  // table geometry
  localparam int SLOTS   = 8;
  localparam int AW      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW      = $clog2(SLOTS + 1);
  localparam int CMPW    = (CW > 3) ? CW : 3;
  localparam int ENTRY_W = 11;

  // time limits
  localparam logic [4:0] HOURS_PER_DAY    = 5'd24;
  localparam logic [5:0] MINUTES_PER_HOUR = 6'd60;

  // operation codes
  localparam logic [2:0] OP_TICK   = 3'd0;
  localparam logic [2:0] OP_ADD    = 3'd1;
  localparam logic [2:0] OP_MODIFY = 3'd2;
  localparam logic [2:0] OP_CLEAR  = 3'd3;
  localparam logic [2:0] OP_ACK    = 3'd4;

  // status codes
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_FULL  = 3'd1;
  localparam logic [2:0] ST_RANGE = 3'd2;
  localparam logic [2:0] ST_DUP   = 3'd3;
  localparam logic [2:0] ST_EMPTY = 3'd4;

  typedef struct packed {
    logic [2:0] op;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [2:0] slot;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic       alarm_on;
    logic       next_valid;
    logic [4:0] next_hour;
    logic [5:0] next_minute;
    logic [3:0] entry_count;
    logic       minute_changed;
  } out_item_t;

  // table memory request from the sequencer
  typedef struct packed {
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [ENTRY_W-1:0] wr_data;
  } mem_req_t;

endpackage

FILE: src/dat_ram.sv
// dat_ram: generic single write port, single read port synchronous memory
// read data registered, available in the cycle after rd_en; no dependencies
module dat_ram #(
  parameter int DEPTH = 8,
  parameter int WIDTH = 11
) (
  input  logic                                     clk,
  input  logic                                     rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data,
  input  logic                                     wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: src/dat_seq.sv
// dat_seq: sequencer for the alarm table, scans the table memory per transaction
// depends on dat_pkg; drives the table memory through a dat_pkg::mem_req_t
module dat_seq (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  dat_pkg::in_item_t     item_in,
  output logic                  res_valid,
  input  logic                  res_take,
  output dat_pkg::out_item_t    res,
  output dat_pkg::mem_req_t     mem_req,
  input  logic [dat_pkg::ENTRY_W-1:0] rd_data
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DUP,
    S_RES,
    S_DONE
  } state_t;

  state_t                       state;
  dat_pkg::in_item_t            item;
  logic [dat_pkg::CW-1:0]       count;
  logic                         acknowledged;
  logic [5:0]                   last_minute;
  logic [4:0]                   now_hour;
  logic [5:0]                   now_minute;
  logic [dat_pkg::CW-1:0]       idx;
  logic                         pend;
  logic [dat_pkg::AW-1:0]       pend_idx;
  logic                         dup;
  logic [2:0]                   status;
  logic                         changed;
  logic                         alarm;
  logic                         nvalid;
  logic [4:0]                   nh;
  logic [5:0]                   nm;

  logic                         scanning;
  logic                         issue;
  logic                         scan_end;
  logic                         skip;
  logic                         hit;
  logic                         dup_now;
  logic                         in_range;
  logic [dat_pkg::ENTRY_W-1:0]  now_key;
  logic [dat_pkg::ENTRY_W-1:0]  best_key;

  assign scanning = (state == S_DUP) || (state == S_RES);
  assign issue    = scanning && (idx < count);
  assign scan_end = scanning && (idx == count);
  assign skip     = (item.op == dat_pkg::OP_MODIFY) &&
                    (dat_pkg::CMPW'(pend_idx) == dat_pkg::CMPW'(item.slot));
  assign hit      = pend && !skip && (rd_data == {item.hour, item.minute});
  assign dup_now  = dup || hit;
  assign in_range = (item_in.hour < dat_pkg::HOURS_PER_DAY) &&
                    (item_in.minute < dat_pkg::MINUTES_PER_HOUR);
  assign now_key  = {now_hour, now_minute};
  assign best_key = {nh, nm};

  always_comb begin
    mem_req.rd_en   = issue;
    mem_req.rd_addr = dat_pkg::AW'(idx);
    mem_req.wr_en   = (state == S_DUP) && scan_end && !dup_now;
    mem_req.wr_addr = (item.op == dat_pkg::OP_ADD) ? dat_pkg::AW'(count)
                                                   : dat_pkg::AW'(item.slot);
    mem_req.wr_data = {item.hour, item.minute};
  end

  assign res_valid          = (state == S_DONE);
  assign res.status         = status;
  assign res.alarm_on       = alarm;
  assign res.next_valid     = nvalid;
  assign res.next_hour      = nh;
  assign res.next_minute    = nm;
  assign res.entry_count    = 4'(count);
  assign res.minute_changed = changed;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      acknowledged <= 1'b0;
      last_minute  <= '0;
      now_hour     <= '0;
      now_minute   <= '0;
      idx          <= '0;
      pend         <= 1'b0;
    end else begin
      if (scanning) begin
        pend     <= issue;
        pend_idx <= dat_pkg::AW'(idx);
        if (issue) begin
          idx <= idx + dat_pkg::CW'(1);
        end
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            item    <= item_in;
            status  <= dat_pkg::ST_OK;
            changed <= 1'b0;
            idx     <= '0;
            pend    <= 1'b0;
            dup     <= 1'b0;
            alarm   <= 1'b0;
            nvalid  <= 1'b0;
            nh      <= '0;
            nm      <= '0;
            state   <= S_RES;
            unique case (item_in.op)
              dat_pkg::OP_TICK: begin
                now_hour   <= item_in.hour;
                now_minute <= item_in.minute;
                if (item_in.minute != last_minute) begin
                  changed      <= 1'b1;
                  acknowledged <= 1'b0;
                  last_minute  <= item_in.minute;
                end
              end
              dat_pkg::OP_ADD: begin
                if (count >= dat_pkg::CW'(dat_pkg::SLOTS)) begin
                  status <= dat_pkg::ST_FULL;
                end else if (!in_range) begin
                  status <= dat_pkg::ST_RANGE;
                end else begin
                  state <= S_DUP;
                end
              end
              dat_pkg::OP_MODIFY: begin
                if (dat_pkg::CMPW'(item_in.slot) >= dat_pkg::CMPW'(count)) begin
                  status <= dat_pkg::ST_EMPTY;
                end else if (!in_range) begin
                  status <= dat_pkg::ST_RANGE;
                end else begin
                  state <= S_DUP;
                end
              end
              dat_pkg::OP_CLEAR: begin
                count <= '0;
              end
              dat_pkg::OP_ACK: begin
                acknowledged <= 1'b1;
              end
              default: begin
              end
            endcase
          end
        end
        S_DUP: begin
          if (hit) begin
            dup <= 1'b1;
          end
          if (scan_end) begin
            idx <= '0;
            if (dup_now) begin
              status <= dat_pkg::ST_DUP;
            end else if (item.op == dat_pkg::OP_ADD) begin
              count <= count + dat_pkg::CW'(1);
            end
            state <= S_RES;
          end
        end
        S_RES: begin
          if (pend) begin
            if (rd_data == now_key && !acknowledged) begin
              alarm <= 1'b1;
            end
            if (rd_data > now_key && (!nvalid || rd_data < best_key)) begin
              nvalid <= 1'b1;
              nh     <= rd_data[10:6];
              nm     <= rd_data[5:0];
            end
          end
          if (scan_end) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: src/multi_slot_daily_alarm_table_core.sv
// tick, clear, acknowledge and edits rejected as full, out of range or on an
// empty slot sweep the table once, for the result; other adds and modifies sweep it
// first for the duplicate check, write the entry if none is found, then sweep again
// for the result; one transaction at a time, over the table memory's single read port
// reset: synchronous, clears count, acknowledge mark, current and last time; entries kept
module multi_slot_daily_alarm_table_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  dat_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output dat_pkg::out_item_t  out_data
);

  // sequencer side signals
  logic                         busy;
  logic                         start;
  logic                         res_valid;
  logic                         res_take;
  dat_pkg::out_item_t           res;
  dat_pkg::mem_req_t            mem_req;
  logic [dat_pkg::ENTRY_W-1:0]  rd_data;

  // one transaction in the sequencer at a time
  assign in_stall = busy;
  assign start    = in_valid && !busy;

  // output register is free when empty or being drained this cycle
  assign res_take = !out_valid || !out_stall;

  // table memory, one {hour, minute} word per slot
  dat_ram #(
    .DEPTH (dat_pkg::SLOTS),
    .WIDTH (dat_pkg::ENTRY_W)
  ) u_ram (
    .clk     (clk),
    .rd_en   (mem_req.rd_en),
    .rd_addr (mem_req.rd_addr),
    .rd_data (rd_data),
    .wr_en   (mem_req.wr_en),
    .wr_addr (mem_req.wr_addr),
    .wr_data (mem_req.wr_data)
  );

  // checks, edits and result sweep
  dat_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .item_in   (in_data),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res),
    .mem_req   (mem_req),
    .rd_data   (rd_data)
  );

  // busy flag and output register; the next transaction may be accepted
  // while the previous result still waits here
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (start) begin
        busy <= 1'b1;
      end
      if (res_valid && res_take) begin
        out_data  <= res;
        out_valid <= 1'b1;
        busy      <= 1'b0;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: verif/tb_top.sv
// tb_top: self-checking testbench for multi_slot_daily_alarm_table_core
// depends on dat_pkg (src/dat_pkg.sv) for the transaction types, op and status codes
`timescale 1ns / 100ps

module tb_top;

  // spare op codes, the block leaves its state alone on these
  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  localparam int N_RANDOM     = 800;
  localparam int QUIET_TAIL   = 100;   // last random items run with no idling
  localparam int DRAIN_CYCLES = 4 * dat_pkg::SLOTS + 8;
  localparam int LIMIT_NS     = 5_000_000;
  localparam int MAX_REPORTS  = 10;

  // one row of the directed plan; typed rows carry their own result
  typedef struct {
    dat_pkg::in_item_t  item;
    bit                 typed;
    dat_pkg::out_item_t res;
  } plan_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  dat_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  dat_pkg::out_item_t out_data;

  // typed expectation travels alongside in_data, driven at the same edges
  bit                 drv_typed = 1'b0;
  dat_pkg::out_item_t drv_typed_res = '0;

  bit        idle_on = 1'b0;
  int        stall_left = 0;
  int        n_mismatch = 0;

  plan_row_t          plan[$];
  dat_pkg::out_item_t expected_results[$];

  // alarm table as the testbench sees it, updated at each accepted transaction
  logic [4:0] tbl_hour [dat_pkg::SLOTS];
  logic [5:0] tbl_min  [dat_pkg::SLOTS];
  int         n_entries = 0;
  bit         ack_mark = 1'b0;
  logic [5:0] prev_min = '0;
  logic [4:0] cur_hour = '0;
  logic [5:0] cur_min = '0;

  multi_slot_daily_alarm_table_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #(LIMIT_NS);
    $display("FAIL");
    $finish;
  end

  function automatic dat_pkg::out_item_t result_of(logic [2:0] st, bit alarm, bit nv,
                                                   logic [4:0] nh, logic [5:0] nm,
                                                   logic [3:0] cnt, bit chg);
    dat_pkg::out_item_t r;
    r.status         = st;
    r.alarm_on       = alarm;
    r.next_valid     = nv;
    r.next_hour      = nh;
    r.next_minute    = nm;
    r.entry_count    = cnt;
    r.minute_changed = chg;
    return r;
  endfunction

  // true if a held entry other than slot skip has this time; skip = SLOTS excludes none
  function automatic bit time_taken(logic [4:0] h, logic [5:0] m, int skip);
    for (int i = 0; i < n_entries; i++) begin
      if (i != skip && tbl_hour[i] == h && tbl_min[i] == m) return 1'b1;
    end
    return 1'b0;
  endfunction

  // applies one transaction to the table and works out the result it gives
  function automatic dat_pkg::out_item_t alarm_table_step(dat_pkg::in_item_t it);
    dat_pkg::out_item_t r;
    bit                 in_day;
    r = '0;
    r.status = dat_pkg::ST_OK;
    in_day = (it.hour < dat_pkg::HOURS_PER_DAY) && (it.minute < dat_pkg::MINUTES_PER_HOUR);
    case (it.op)
      dat_pkg::OP_TICK: begin
        // out-of-range times are kept raw, they simply match nothing
        cur_hour = it.hour;
        cur_min  = it.minute;
        if (it.minute != prev_min) begin
          r.minute_changed = 1'b1;
          ack_mark = 1'b0;
          prev_min = it.minute;
        end
      end
      dat_pkg::OP_ADD: begin
        // full beats range beats duplicate
        if (n_entries >= dat_pkg::SLOTS) begin
          r.status = dat_pkg::ST_FULL;
        end else if (!in_day) begin
          r.status = dat_pkg::ST_RANGE;
        end else if (time_taken(it.hour, it.minute, dat_pkg::SLOTS)) begin
          r.status = dat_pkg::ST_DUP;
        end else begin
          tbl_hour[n_entries] = it.hour;
          tbl_min[n_entries]  = it.minute;
          n_entries++;
        end
      end
      dat_pkg::OP_MODIFY: begin
        // a slot may be rewritten with its own time
        if (int'(it.slot) >= n_entries) begin
          r.status = dat_pkg::ST_EMPTY;
        end else if (!in_day) begin
          r.status = dat_pkg::ST_RANGE;
        end else if (time_taken(it.hour, it.minute, int'(it.slot))) begin
          r.status = dat_pkg::ST_DUP;
        end else begin
          tbl_hour[it.slot] = it.hour;
          tbl_min[it.slot]  = it.minute;
        end
      end
      dat_pkg::OP_CLEAR: n_entries = 0;
      dat_pkg::OP_ACK:   ack_mark = 1'b1;
      default: ;
    endcase
    for (int i = 0; i < n_entries; i++) begin
      if (tbl_hour[i] == cur_hour && tbl_min[i] == cur_min && !ack_mark) r.alarm_on = 1'b1;
      if (tbl_hour[i] > cur_hour || (tbl_hour[i] == cur_hour && tbl_min[i] > cur_min)) begin
        if (!r.next_valid || tbl_hour[i] < r.next_hour ||
            (tbl_hour[i] == r.next_hour && tbl_min[i] < r.next_minute)) begin
          r.next_valid  = 1'b1;
          r.next_hour   = tbl_hour[i];
          r.next_minute = tbl_min[i];
        end
      end
    end
    r.entry_count = 4'(n_entries);
    return r;
  endfunction

  function automatic void plan_row(logic [2:0] op, logic [4:0] h, logic [5:0] m,
                                   logic [2:0] s);
    plan_row_t p;
    p.item  = '{op: op, hour: h, minute: m, slot: s};
    p.typed = 1'b0;
    p.res   = '0;
    plan.push_back(p);
  endfunction

  function automatic void plan_typed(logic [2:0] op, logic [4:0] h, logic [5:0] m,
                                     logic [2:0] s, dat_pkg::out_item_t res);
    plan_row_t p;
    p.item  = '{op: op, hour: h, minute: m, slot: s};
    p.typed = 1'b1;
    p.res   = res;
    plan.push_back(p);
  endfunction

  // a time that is often already in the table, so duplicates and alarms come up
  function automatic void pick_time(output logic [4:0] h, output logic [5:0] m);
    int r;
    int k;
    r = $urandom_range(0, 99);
    if (r < 30 && n_entries > 0) begin
      k = $urandom_range(0, n_entries - 1);
      h = tbl_hour[k];
      m = tbl_min[k];
    end else if (r < 85) begin
      h = 5'($urandom_range(0, 23));
      m = 6'($urandom_range(0, 59));
    end else begin
      h = 5'($urandom_range(0, 31));
      m = 6'($urandom_range(0, 63));
    end
  endfunction

  function automatic dat_pkg::in_item_t random_request();
    dat_pkg::in_item_t it;
    int                r;
    r = $urandom_range(0, 99);
    // slots mostly land on held entries or just past the end of the table
    if ($urandom_range(0, 4) == 0) begin
      it.slot = 3'($urandom_range(0, 7));
    end else begin
      it.slot = 3'($urandom_range(0, (n_entries < dat_pkg::SLOTS) ? n_entries
                                                                  : dat_pkg::SLOTS - 1));
    end
    pick_time(it.hour, it.minute);
    if (r < 35) begin
      it.op = dat_pkg::OP_TICK;
      // a tick in the same minute keeps an acknowledge in force
      if ($urandom_range(0, 2) == 0) it.minute = cur_min;
    end else if (r < 60) begin
      it.op = dat_pkg::OP_ADD;
    end else if (r < 80) begin
      it.op = dat_pkg::OP_MODIFY;
    end else if (r < 84) begin
      it.op = dat_pkg::OP_CLEAR;
    end else if (r < 94) begin
      it.op = dat_pkg::OP_ACK;
    end else begin
      it.op = 3'($urandom_range(32'(OP_SPARE_LO), 32'(OP_SPARE_HI)));
    end
    return it;
  endfunction

  function automatic string show(dat_pkg::out_item_t r);
    return $sformatf("status %0d alarm %0d next %0d %0d:%0d count %0d changed %0d",
                     r.status, r.alarm_on, r.next_valid, r.next_hour, r.next_minute,
                     r.entry_count, r.minute_changed);
  endfunction

  task automatic note_mismatch(string what, dat_pkg::out_item_t exp, dat_pkg::out_item_t act);
    n_mismatch++;
    if (n_mismatch <= MAX_REPORTS) begin
      $display("%0t mismatch (%s): expected %s / got %s", $realtime, what, show(exp), show(act));
    end
  endtask

  // offers one transaction, with an optional idle gap first, and returns at its accept edge
  task automatic send_request(dat_pkg::in_item_t it, bit typed, dat_pkg::out_item_t res);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_data       <= it;
    drv_typed     <= typed;
    drv_typed_res <= res;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // receiver stalls in random bursts while idling is on
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(0, 4);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // result check first, then prediction for a transaction accepted on the same edge
  always @(posedge clk) begin
    dat_pkg::out_item_t exp;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        note_mismatch("result with nothing outstanding", '0, out_data);
      end else begin
        exp = expected_results.pop_front();
        if (exp.status !== out_data.status || exp.alarm_on !== out_data.alarm_on ||
            exp.next_valid !== out_data.next_valid || exp.next_hour !== out_data.next_hour ||
            exp.next_minute !== out_data.next_minute ||
            exp.entry_count !== out_data.entry_count ||
            exp.minute_changed !== out_data.minute_changed) begin
          note_mismatch("field", exp, out_data);
        end
      end
    end
    if (!rst && in_valid && !in_stall) begin
      // the table copy is advanced for every transaction, typed rows included
      exp = alarm_table_step(in_data);
      expected_results.push_back(drv_typed ? drv_typed_res : exp);
    end
  end

  initial begin
    // after reset: first tick at minute 0 is not a minute change
    plan_typed(dat_pkg::OP_TICK, 5'd0, 6'd0, 3'd0,
               result_of(dat_pkg::ST_OK, 1'b0, 1'b0, 5'd0, 6'd0, 4'd0, 1'b0));
    // modify on an empty table
    plan_typed(dat_pkg::OP_MODIFY, 5'd10, 6'd10, 3'd0,
               result_of(dat_pkg::ST_EMPTY, 1'b0, 1'b0, 5'd0, 6'd0, 4'd0, 1'b0));
    // range checks on hour, minute and both at their extremes
    plan_typed(dat_pkg::OP_ADD, 5'd24, 6'd0, 3'd0,
               result_of(dat_pkg::ST_RANGE, 1'b0, 1'b0, 5'd0, 6'd0, 4'd0, 1'b0));
    plan_typed(dat_pkg::OP_ADD, 5'd23, 6'd60, 3'd0,
               result_of(dat_pkg::ST_RANGE, 1'b0, 1'b0, 5'd0, 6'd0, 4'd0, 1'b0));
    plan_typed(dat_pkg::OP_ADD, 5'd31, 6'd63, 3'd7,
               result_of(dat_pkg::ST_RANGE, 1'b0, 1'b0, 5'd0, 6'd0, 4'd0, 1'b0));
    // entry at the current time sounds the alarm, a second copy is a duplicate
    plan_typed(dat_pkg::OP_ADD, 5'd0, 6'd0, 3'd0,
               result_of(dat_pkg::ST_OK, 1'b1, 1'b0, 5'd0, 6'd0, 4'd1, 1'b0));
    plan_typed(dat_pkg::OP_ADD, 5'd0, 6'd0, 3'd0,
               result_of(dat_pkg::ST_DUP, 1'b1, 1'b0, 5'd0, 6'd0, 4'd1, 1'b0));
    plan_typed(dat_pkg::OP_ACK, 5'd0, 6'd0, 3'd0,
               result_of(dat_pkg::ST_OK, 1'b0, 1'b0, 5'd0, 6'd0, 4'd1, 1'b0));
    plan_row(dat_pkg::OP_ADD, 5'd23, 6'd59, 3'd0);
    // same minute keeps the acknowledge, the next minute clears it
    plan_row(dat_pkg::OP_TICK, 5'd0, 6'd0, 3'd0);
    plan_row(dat_pkg::OP_TICK, 5'd0, 6'd1, 3'd0);
    // fill the table
    plan_row(dat_pkg::OP_ADD, 5'd12, 6'd30, 3'd0);
    plan_row(dat_pkg::OP_ADD, 5'd6, 6'd15, 3'd0);
    plan_row(dat_pkg::OP_ADD, 5'd18, 6'd45, 3'd0);
    plan_row(dat_pkg::OP_ADD, 5'd0, 6'd1, 3'd0);
    plan_row(dat_pkg::OP_ADD, 5'd2, 6'd2, 3'd0);
    plan_row(dat_pkg::OP_ADD, 5'd3, 6'd3, 3'd0);
    // full wins over range
    plan_row(dat_pkg::OP_ADD, 5'd4, 6'd4, 3'd0);
    plan_row(dat_pkg::OP_ADD, 5'd31, 6'd63, 3'd0);
    // modify: duplicate of another slot, own time, out of range
    plan_row(dat_pkg::OP_MODIFY, 5'd0, 6'd0, 3'd7);
    plan_row(dat_pkg::OP_MODIFY, 5'd3, 6'd3, 3'd7);
    plan_row(dat_pkg::OP_MODIFY, 5'd24, 6'd0, 3'd7);
    // tick out of range is stored raw and matches nothing
    plan_row(dat_pkg::OP_TICK, 5'd31, 6'd63, 3'd0);
    plan_row(OP_SPARE_LO, 5'd31, 6'd63, 3'd7);
    plan_row(OP_SPARE_HI, 5'd0, 6'd0, 3'd0);
    plan_typed(dat_pkg::OP_CLEAR, 5'd0, 6'd0, 3'd0,
               result_of(dat_pkg::ST_OK, 1'b0, 1'b0, 5'd0, 6'd0, 4'd0, 1'b0));

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    idle_on = 1'b1;

    foreach (plan[i]) send_request(plan[i].item, plan[i].typed, plan[i].res);

    // random part: idling in stretches, then a quiet tail
    for (int n = 0; n < N_RANDOM; n++) begin
      idle_on = (n < N_RANDOM - QUIET_TAIL) && ((n / 64) % 3 != 2);
      send_request(random_request(), 1'b0, '0);
    end
    in_valid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (n_mismatch == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
src/dat_pkg.sv
src/dat_ram.sv
src/dat_seq.sv
src/multi_slot_daily_alarm_table_core.sv
verif/tb_top.sv
